// ===== rtl/core/tsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp validator package
// Shared constants, the gathered field record and the calendar helpers.
// ----------------------------------------------------------------------------
package tsv_pkg;

  localparam int unsigned PosW   = 5;
  localparam int unsigned ValW   = 7;
  localparam int unsigned CharW  = 8;

  // A complete timestamp has this many characters.
  localparam logic [PosW-1:0] TsLen  = 5'd19;
  // The position counter stops here.
  localparam logic [PosW-1:0] PosSat = 5'd20;

  localparam logic [CharW-1:0] CharDash  = 8'h2D;
  localparam logic [CharW-1:0] CharUnder = 8'h5F;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharNone  = 8'h00;

  localparam logic [ValW-1:0] MonthMax  = 7'd12;
  localparam logic [ValW-1:0] HourMax   = 7'd23;
  localparam logic [ValW-1:0] MinSecMax = 7'd59;
  localparam logic [ValW-1:0] FebLeap   = 7'd29;

  // The year is kept as its two upper and its two lower decimal digits, which
  // makes the century and leap-year tests plain bit tests.
  typedef struct packed {
    logic [ValW-1:0] year_hi;
    logic [ValW-1:0] year_lo;
    logic [ValW-1:0] month;
    logic [ValW-1:0] day;
    logic [ValW-1:0] hour;
    logic [ValW-1:0] minute;
    logic [ValW-1:0] second;
  } ts_fields_t;

  // Separator demanded at a position, or CharNone where a digit is due.
  function automatic logic [CharW-1:0] sep_char(input logic [PosW-1:0] pos);
    logic [CharW-1:0] c;
    case (pos)
      5'd4, 5'd7, 5'd13, 5'd16: c = CharDash;
      5'd10:                    c = CharUnder;
      default:                  c = CharNone;
    endcase
    return c;
  endfunction

  // Days in a month numbered 1 to 12.
  function automatic logic [ValW-1:0] month_days(input logic [ValW-1:0] month,
                                                 input logic leap);
    logic [ValW-1:0] d;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 7'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                     d = 7'd30;
      7'd2:    d = leap ? FebLeap : 7'd28;
      default: d = 7'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/timestamp_string_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp string validator
// Checks streamed strings against the form YYYY-MM-DD_HH-MM-SS and the
// Gregorian calendar.
// ----------------------------------------------------------------------------
// The block takes one character beat per cycle and gives one verdict beat for
// each terminator beat, none for ordinary characters. The per-character
// update of the position counter, the format flag and the decimal field
// registers is a single shallow step, and the verdict is worked out from those
// registers as the terminator is taken and placed in the result register. The
// input is stalled only while a verdict is held in the result register and the
// downstream side stalls it, so with a free-running consumer the sustained rate
// is one beat per cycle. After each terminator the position counter, format
// flag and fields return to their reset values, ready for the next string.
// ----------------------------------------------------------------------------
module timestamp_string_validator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tsv_pkg::CharW-1:0]    char_code_i,
  input  logic                         is_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         valid_res_o
);
  import tsv_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic            fmt_q, fmt_d;
  ts_fields_t      fld_q, fld_d;
  logic            out_valid_q, out_valid_d;
  logic            res_q;

  logic            in_acc;
  logic            verdict;
  logic [CharW-1:0] sep;
  logic            is_digit;
  logic [3:0]      digit;

  // A field value gains one decimal digit; two digits at most, so it fits.
  function automatic logic [ValW-1:0] add_digit(input logic [ValW-1:0] v,
                                                input logic [3:0] d);
    logic [10:0] s;
    s = ({4'd0, v} * 11'd10) + {7'd0, d};
    return s[ValW-1:0];
  endfunction

  // The result register can take a new verdict whenever it is empty or being
  // emptied in this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  tsv_verdict u_verdict (
    .fields_i    (fld_q),
    .pos_i       (pos_q),
    .format_ok_i (fmt_q),
    .ok_o        (verdict)
  );

  always_comb begin
    sep      = sep_char(pos_q);
    is_digit = (char_code_i >= CharZero) && (char_code_i <= CharNine);
    digit    = 4'(char_code_i - CharZero);

    pos_d = pos_q;
    fmt_d = fmt_q;
    fld_d = fld_q;

    if (in_acc) begin
      if (is_end_i) begin
        // The terminator closes the string and returns the counter, format flag and fields to reset.
        pos_d = '0;
        fmt_d = 1'b1;
        fld_d = '0;
      end else begin
        if (pos_q < TsLen) begin
          if (sep != CharNone) begin
            if (char_code_i != sep) begin
              fmt_d = 1'b0;
            end
          end else if (is_digit) begin
            case (pos_q)
              5'd0, 5'd1:   fld_d.year_hi = add_digit(fld_q.year_hi, digit);
              5'd2, 5'd3:   fld_d.year_lo = add_digit(fld_q.year_lo, digit);
              5'd5, 5'd6:   fld_d.month   = add_digit(fld_q.month, digit);
              5'd8, 5'd9:   fld_d.day     = add_digit(fld_q.day, digit);
              5'd11, 5'd12: fld_d.hour    = add_digit(fld_q.hour, digit);
              5'd14, 5'd15: fld_d.minute  = add_digit(fld_q.minute, digit);
              default:      fld_d.second  = add_digit(fld_q.second, digit);
            endcase
          end else begin
            fmt_d = 1'b0;
          end
        end
        // Strings longer than the format saturate the counter and fail.
        if (pos_q < PosSat) begin
          pos_d = pos_q + 5'd1;
        end
      end
    end

    // Result register: loads on a terminator, drains when not stalled.
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc && is_end_i) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fmt_q       <= 1'b1;
      fld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      fmt_q       <= fmt_d;
      fld_q       <= fld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_end_i) begin
      res_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

endmodule

// ===== rtl/core/tsv_verdict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp verdict
// Decides from the gathered fields whether a closed string is a valid date.
// ----------------------------------------------------------------------------
module tsv_verdict (
  input  tsv_pkg::ts_fields_t        fields_i,
  input  logic [tsv_pkg::PosW-1:0]   pos_i,
  input  logic                       format_ok_i,
  output logic                       ok_o
);
  import tsv_pkg::*;

  logic            year_ok;
  logic            leap;
  logic [ValW-1:0] max_day;

  always_comb begin
    year_ok = (fields_i.year_hi != '0) || (fields_i.year_lo != '0);
    // Gregorian rule: a century year is leap only when divisible by 400.
    if (fields_i.year_lo != '0) begin
      leap = (fields_i.year_lo[1:0] == 2'b00);
    end else begin
      leap = (fields_i.year_hi[1:0] == 2'b00);
    end
    max_day = month_days(fields_i.month, leap);
    ok_o = format_ok_i && (pos_i == TsLen) && year_ok
        && (fields_i.month != '0) && (fields_i.month <= MonthMax)
        && (fields_i.hour <= HourMax) && (fields_i.minute <= MinSecMax)
        && (fields_i.second <= MinSecMax)
        && (fields_i.day != '0) && (fields_i.day <= max_day);
  end

endmodule

// ===== tb/tsv_verdict_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp verdict scoreboard
// Predicts the verdict of every terminated string from the character beats
// taken by the validator and compares it with the verdict beats given back.
// ----------------------------------------------------------------------------
package tsv_verdict_check_pkg;

  import tsv_pkg::*;

  class verdict_scoreboard;

    // Mirror of the string being gathered.
    logic [PosW-1:0] pos_cnt;
    logic            fmt_good;
    logic [13:0]     yr;
    logic [ValW-1:0] mon;
    logic [ValW-1:0] dy;
    logic [ValW-1:0] hr;
    logic [ValW-1:0] mi;
    logic [ValW-1:0] se;

    int unsigned days_in_month[12];
    logic        pending_verdicts[$];
    int          failures;

    function new();
      days_in_month = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      failures = 0;
      clear_fields();
    endfunction

    function void clear_fields();
      pos_cnt  = '0;
      fmt_good = 1'b1;
      yr       = '0;
      mon      = '0;
      dy       = '0;
      hr       = '0;
      mi       = '0;
      se       = '0;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // Called for every accepted input beat.
    function void note_beat(logic [CharW-1:0] c, logic e);
      logic [CharW-1:0] sep;
      logic [3:0]       d;
      int unsigned      maxd;
      logic             leap;
      logic             ok;
      if (e) begin
        ok = fmt_good && (pos_cnt == TsLen) && (yr >= 1) && (mon >= 1) &&
             (mon <= MonthMax) && (hr <= HourMax) && (mi <= MinSecMax) &&
             (se <= MinSecMax);
        if (ok) begin
          maxd = days_in_month[mon - 1];
          leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
          if (mon == 2 && leap) maxd = FebLeap;
          ok = (dy >= 1) && (dy <= maxd);
        end
        pending_verdicts.push_back(ok);
        clear_fields();
        return;
      end
      if (pos_cnt < TsLen) begin
        case (pos_cnt)
          5'd4, 5'd7, 5'd13, 5'd16: sep = CharDash;
          5'd10:                    sep = CharUnder;
          default:                  sep = CharNone;
        endcase
        if (sep != CharNone) begin
          if (c != sep) fmt_good = 1'b0;
        end else if (c >= CharZero && c <= CharNine) begin
          d = 4'(c - CharZero);
          if (pos_cnt <= 3)       yr  = 14'(yr * 10 + d);
          else if (pos_cnt <= 6)  mon = 7'(mon * 10 + d);
          else if (pos_cnt <= 9)  dy  = 7'(dy * 10 + d);
          else if (pos_cnt <= 12) hr  = 7'(hr * 10 + d);
          else if (pos_cnt <= 15) mi  = 7'(mi * 10 + d);
          else                    se  = 7'(se * 10 + d);
        end else begin
          fmt_good = 1'b0;
        end
      end
      if (pos_cnt < PosSat) pos_cnt = pos_cnt + 1'b1;
    endfunction

    // Called for every accepted verdict beat.
    function void check_verdict(logic v);
      logic want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict beat %0b arrived with no terminator pending", $time, v);
        failures++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (want !== v) begin
        $display("%0t: verdict mismatch, expected %0b, actual %0b", $time, want, v);
        failures++;
      end
    endfunction

  endclass

endpackage

// ===== tb/timestamp_string_validator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp string validator test
// Streams directed and random strings, mostly well-formed timestamps with
// edge values and damaged copies of them, under several idle and stall
// patterns, and checks every verdict against a predicted one.
// ----------------------------------------------------------------------------
module timestamp_string_validator_test;

  import tsv_pkg::*;
  import tsv_verdict_check_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CharW-1:0] char_code_i;
  logic             is_end_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             valid_res_o;

  verdict_scoreboard sb;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // A request for a long receiver hold-off, and the cycles of it still left.
  int hold_req  = 0;
  int hold_left = 0;
  int beats_sent = 0;

  // Years that sit on the edges of the range and of the leap-year rule.
  int unsigned edge_years[10] = '{0, 1, 1600, 1900, 1999, 2000, 2004, 2100, 2400, 9999};
  int unsigned sep_positions[5] = '{4, 7, 10, 13, 16};

  timestamp_string_validator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .is_end_i    (is_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .valid_res_o (valid_res_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver. A pending hold request is taken over into a local count, so
  // that the stall stays high for that many cycles regardless of the sender.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor. Both channels are sampled at the rising edge, before any
  // register of the block or any driven input has moved.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_beat(char_code_i, is_end_i);
      if (out_valid_o && !out_stall_i) sb.check_verdict(valid_res_o);
    end
  end

  // Offers one beat, after a random number of idle cycles, and returns at
  // the edge at which the block takes it.
  task automatic send_beat(input logic [CharW-1:0] c, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    is_end_i    <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // The character beats of a string, then its terminator. The character
  // field of the terminator is random, since the block ignores it.
  task automatic send_string(ref logic [CharW-1:0] s[$]);
    foreach (s[i]) send_beat(s[i], 1'b0);
    send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  // Lowers valid and waits until every terminator has had its verdict.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic push_num(ref logic [CharW-1:0] s[$], input int unsigned v,
                          input int unsigned ndig);
    int unsigned div;
    div = (ndig == 4) ? 1000 : 10;
    while (div > 0) begin
      s.push_back(8'(CharZero + (v / div) % 10));
      div = div / 10;
    end
  endtask

  // Builds one candidate string. Most are well-formed timestamps whose
  // fields lean towards their limits; some are damaged by a replaced,
  // dropped or extra character, by truncation or lengthening, or by a
  // swapped separator; a few are plain noise.
  task automatic make_candidate(ref logic [CharW-1:0] s[$]);
    int unsigned yv, mov, dv, hv, miv, sv, k, n, idx, p;
    s = {};
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(24);
      repeat (n) s.push_back(8'($urandom_range(255)));
      return;
    end
    yv = ($urandom_range(2) == 0) ? edge_years[$urandom_range(9)] : $urandom_range(9999);
    case ($urandom_range(9))
      0:       mov = $urandom_range(99);
      1:       mov = $urandom_range(1) ? 0 : 13;
      2, 3:    mov = 2;
      default: mov = $urandom_range(12, 1);
    endcase
    case ($urandom_range(4))
      0:       dv = $urandom_range(99);
      1, 2:    dv = 28 + $urandom_range(4);
      3:       dv = $urandom_range(1);
      default: dv = $urandom_range(28, 1);
    endcase
    k = $urandom_range(9);
    hv  = (k == 0) ? $urandom_range(99) : (k == 1) ? 23 + $urandom_range(1)
                                                     : $urandom_range(23);
    k = $urandom_range(9);
    miv = (k == 0) ? $urandom_range(99) : (k == 1) ? 59 + $urandom_range(1)
                                                     : $urandom_range(59);
    k = $urandom_range(9);
    sv  = (k == 0) ? $urandom_range(99) : (k == 1) ? 59 + $urandom_range(1)
                                                     : $urandom_range(59);
    push_num(s, yv, 4);
    s.push_back(CharDash);
    push_num(s, mov, 2);
    s.push_back(CharDash);
    push_num(s, dv, 2);
    s.push_back(CharUnder);
    push_num(s, hv, 2);
    s.push_back(CharDash);
    push_num(s, miv, 2);
    s.push_back(CharDash);
    push_num(s, sv, 2);

    k   = $urandom_range(99);
    idx = $urandom_range(s.size() - 1);
    if (k < 60) begin
      // Left well-formed.
    end else if (k < 70) begin
      s[idx] = 8'($urandom_range(255));
    end else if (k < 78) begin
      if ($urandom_range(1)) s.delete(idx);
      else s.insert(idx, 8'(CharZero + $urandom_range(9)));
    end else if (k < 86) begin
      // Too long: the position counter saturates.
      n = $urandom_range(12, 1);
      repeat (n) begin
        if ($urandom_range(1)) s.push_back(8'(CharZero + $urandom_range(9)));
        else s.push_back(8'($urandom_range(255)));
      end
    end else if (k < 93) begin
      n = $urandom_range(18);
      while (s.size() > n) void'(s.pop_back());
    end else begin
      p = sep_positions[$urandom_range(4)];
      s[p] = (s[p] == CharDash) ? CharUnder : CharDash;
    end
  endtask

  initial begin
    logic [CharW-1:0] str[$];
    string            leap_edge;
    int               ph;
    int               phase_end;
    bit               paused;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    is_end_i    = 1'b0;
    out_stall_i = 1'b0;
    leap_edge   = "2000-02-29_23-59-59";
    paused      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: an empty string, a short string of a zero byte and an
    // all-ones byte, and a valid timestamp on the leap day of a century
    // divisible by 400 at the last second of the day.
    send_beat(8'hFF, 1'b1);
    send_beat(CharNone, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    foreach (leap_edge[i]) send_beat(leap_edge[i], 1'b0);
    send_beat(8'hA5, 1'b1);
    wait_drained();

    // Random part in four phases of idling and stalling. The first opens with a long
    // receiver hold-off, so that a verdict is held and the input backs up.
    // Halfway through the third, the sender waits for every verdict.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      phase_end = beats_sent + 350;
      if (ph == 0) hold_req = 400;
      while (beats_sent < phase_end) begin
        if (ph == 2 && !paused && beats_sent > phase_end - 175) begin
          paused = 1'b1;
          wait_drained();
        end
        make_candidate(str);
        send_string(str);
      end
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
